// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the parser RTL.
// Both macros sample on i_clk and are held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ANP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ANP_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/anp_pkg.sv =====
package anp_pkg;

    // Parse phases
    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_QUOTE,
        PH_DIGITS,
        PH_STOPPED,
        PH_CHAR
    } t_phase;

    // Number base selected by the prefix
    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_HEX,
        RADIX_BIN
    } t_radix;

    // Decoded digit, before the radix filter
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_QUOTE = 8'd39;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_LC_A  = 8'd97;
    localparam logic [7:0] CH_LC_F  = 8'd102;
    localparam logic [7:0] CH_UC_A  = 8'd65;
    localparam logic [7:0] CH_UC_F  = 8'd70;
    localparam logic [7:0] CH_LC_X  = 8'd120;
    localparam logic [7:0] CH_LC_B  = 8'd98;

    localparam int         PREFIX_BITS = 4;
    localparam logic [31:0] VALUE_NONE = 32'hFFFF_FFFF;

    // Hex-style digit decode, upper or lower case
    function automatic t_digit anp_digit(input logic [7:0] c);
        t_digit d;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_ZERO);
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_LC_A + 8'd10);
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_UC_A + 8'd10);
        end
        return d;
    endfunction

    function automatic logic anp_is_space(input logic [7:0] c);
        return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    endfunction

endpackage

// ===== sv/anp_acc.sv =====
module anp_acc #(
    parameter int ACCUM_BITS = 63
) (
    input  anp_pkg::t_radix        i_radix,
    input  logic [ACCUM_BITS-1:0]  i_magnitude,
    input  logic [7:0]             i_character,
    output logic                   o_is_digit,
    output logic [ACCUM_BITS-1:0]  o_magnitude
);
    import anp_pkg::*;

    localparam int WIDE = ACCUM_BITS + PREFIX_BITS;

    t_digit            dig;
    logic [WIDE-1:0]   wide;
    logic [WIDE-1:0]   prod;
    logic [WIDE-1:0]   sum;

    // Digit decode and radix filter
    always_comb begin
        dig = anp_digit(i_character);
        unique case (i_radix)
            RADIX_HEX: o_is_digit = dig.ok;
            RADIX_BIN: o_is_digit = dig.ok && dig.val <= 4'd1;
            RADIX_DEC: o_is_digit = dig.ok && dig.val <= 4'd9;
            default:   o_is_digit = dig.ok;
        endcase
    end

    // Shift-add accumulate; any carry into the top nibble means saturation
    always_comb begin
        wide = {{PREFIX_BITS{1'b0}}, i_magnitude};
        unique case (i_radix)
            RADIX_HEX: prod = wide << 4;
            RADIX_BIN: prod = wide << 1;
            default:   prod = (wide << 3) + (wide << 1);
        endcase
        sum = prod + WIDE'(dig.val);
        if (|sum[WIDE-1:ACCUM_BITS]) begin
            o_magnitude = '1;
        end else begin
            o_magnitude = sum[ACCUM_BITS-1:0];
        end
    end

endmodule

// ===== sv/anp_parse.sv =====
`include "assert_macros.svh"

module anp_parse #(
    parameter int ACCUM_BITS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic [7:0]  i_character,
    input  logic        i_last,
    output logic [31:0] o_value,
    output logic        o_no_number
);
    import anp_pkg::*;

    t_phase                r_phase, n_phase;
    t_radix                r_radix, n_radix;
    logic                  r_negative, n_negative;
    logic                  r_digit_seen, n_digit_seen;
    logic [ACCUM_BITS-1:0] r_magnitude, n_magnitude;

    logic                  acc_is_digit;
    logic [ACCUM_BITS-1:0] acc_magnitude;
    logic                  start_num;
    logic                  take_digit;
    logic [31:0]           mag_lo;

    // Digit accumulator
    anp_acc #(
        .ACCUM_BITS (ACCUM_BITS)
    ) u_acc (
        .i_radix     (r_radix),
        .i_magnitude (r_magnitude),
        .i_character (i_character),
        .o_is_digit  (acc_is_digit),
        .o_magnitude (acc_magnitude)
    );

    // Which path this byte takes
    always_comb begin
        start_num  = (r_phase == PH_SPACE && !anp_is_space(i_character)
                      && i_character != CH_PLUS && i_character != CH_MINUS)
                     || r_phase == PH_SIGNED;
        take_digit = (start_num && i_character != CH_QUOTE && i_character != CH_ZERO)
                     || r_phase == PH_DIGITS
                     || (r_phase == PH_ZERO && i_character != CH_LC_X
                         && i_character != CH_LC_B);
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (take_digit) begin
            n_phase = acc_is_digit ? PH_DIGITS : PH_STOPPED;
        end else begin
            unique case (r_phase)
                PH_SPACE, PH_SIGNED: begin
                    if (start_num) begin
                        n_phase = (i_character == CH_QUOTE) ? PH_QUOTE : PH_ZERO;
                    end else if (!anp_is_space(i_character)) begin
                        n_phase = PH_SIGNED;
                    end
                end
                PH_ZERO:  n_phase = PH_DIGITS;
                PH_QUOTE: n_phase = PH_CHAR;
                default:  n_phase = r_phase;
            endcase
        end
    end

    // Data state updates
    always_comb begin
        n_radix      = r_radix;
        n_negative   = r_negative;
        n_digit_seen = r_digit_seen;
        n_magnitude  = r_magnitude;
        if (take_digit) begin
            if (acc_is_digit) begin
                n_digit_seen = 1'b1;
                n_magnitude  = acc_magnitude;
            end
        end else begin
            unique case (r_phase)
                PH_SPACE: begin
                    if (i_character == CH_PLUS || i_character == CH_MINUS) begin
                        n_negative = (i_character == CH_MINUS);
                    end else if (start_num && i_character == CH_ZERO) begin
                        n_digit_seen = 1'b1;
                        n_magnitude  = '0;
                    end
                end
                PH_SIGNED: begin
                    if (i_character == CH_ZERO) begin
                        n_digit_seen = 1'b1;
                        n_magnitude  = '0;
                    end
                end
                PH_ZERO: begin
                    n_radix      = (i_character == CH_LC_X) ? RADIX_HEX : RADIX_BIN;
                    n_digit_seen = 1'b0;
                    n_magnitude  = '0;
                end
                PH_QUOTE: n_magnitude = ACCUM_BITS'(i_character);
                default:  n_magnitude = r_magnitude;
            endcase
        end
    end

    // Result from the updated state
    always_comb begin
        mag_lo      = n_magnitude[31:0];
        o_value     = VALUE_NONE;
        o_no_number = 1'b1;
        if (n_phase == PH_CHAR) begin
            o_value     = {{24{n_magnitude[7]}}, n_magnitude[7:0]};
            o_no_number = 1'b0;
        end else if (n_digit_seen && n_phase != PH_QUOTE) begin
            o_value     = n_negative ? (32'd0 - mag_lo) : mag_lo;
            o_no_number = 1'b0;
        end
    end

    // Parser state; a last beat returns everything to the start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_last)) begin
            r_phase      <= PH_SPACE;
            r_radix      <= RADIX_DEC;
            r_negative   <= 1'b0;
            r_digit_seen <= 1'b0;
            r_magnitude  <= '0;
        end else if (i_adv) begin
            r_phase      <= n_phase;
            r_radix      <= n_radix;
            r_negative   <= n_negative;
            r_digit_seen <= n_digit_seen;
            r_magnitude  <= n_magnitude;
        end
    end

    `ANP_ASSERT_NXT(a_last_restarts, i_adv && i_last, r_phase == PH_SPACE && !r_digit_seen, "parser not restarted after last beat")
    `ANP_ASSERT_IMP(a_char_narrow, r_phase == PH_CHAR, r_magnitude[ACCUM_BITS-1:8] == '0, "quoted byte wider than 8 bits")
    `ANP_ASSERT_IMP(a_radix_phase, r_radix != RADIX_DEC, r_phase == PH_DIGITS || r_phase == PH_STOPPED, "prefix radix outside digit phases")

endmodule

// ===== sv/ascii_number_parser_core.sv =====
// ASCII number parser. Takes a string one byte per beat, the final byte marked
// by i_last, and returns one registered signed 32-bit value per string after
// that final byte is taken. Leading whitespace is skipped, one optional sign is
// taken, a quote returns the following byte sign-extended, and a lower-case
// "0x" or "0b" selects hex or binary (decimal otherwise). Digits are gathered
// until the first non-digit with the magnitude saturating at 2^ACCUM_BITS-1;
// an empty number gives -1 with o_no_number set. Throughput is one byte per
// clock unless a final byte waits on a stalled result: each byte goes through
// an input register, a single shift-add step of the accumulator, and, for the
// final byte, an output register. Both sides use valid/ready and a stalled
// result does not block input bytes that produce no result.
`include "assert_macros.svh"

module ascii_number_parser_core #(
    parameter int ACCUM_BITS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_character,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_value,
    output logic        o_no_number
);
    import anp_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic        r_out_no_number;

    logic        out_free;
    logic        s1_adv;
    logic [31:0] res_value;
    logic        res_no_number;

    // Stage handshakes
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_in_valid && (!r_in_last || out_free);
    assign o_in_ready = !r_in_valid || s1_adv;

    // Input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_char <= i_character;
            r_in_last <= i_last;
        end
    end

    // Parser state and step logic
    anp_parse #(
        .ACCUM_BITS (ACCUM_BITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (s1_adv),
        .i_character (r_in_char),
        .i_last      (r_in_last),
        .o_value     (res_value),
        .o_no_number (res_no_number)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_in_last) begin
            r_out_value     <= res_value;
            r_out_no_number <= res_no_number;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_no_number = r_out_no_number;

    `ANP_ASSERT_NXT(a_last_gives_result, s1_adv && r_in_last, r_out_valid, "final beat produced no result")
    `ANP_ASSERT_NXT(a_in_held, r_in_valid && !s1_adv, r_in_valid && $stable(r_in_char), "input beat lost while stalled")
    `ANP_ASSERT_IMP(a_none_is_minus_one, r_out_valid && r_out_no_number, r_out_value == VALUE_NONE, "no_number with a value other than -1")

endmodule
